/* rtl/azimuth_bin_select_resynth_defines.svh */
// Assertion macros shared by the checker of the azimuth bin selector.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef AZIMUTH_BIN_SELECT_RESYNTH_DEFINES_SVH
`define AZIMUTH_BIN_SELECT_RESYNTH_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define AZBS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("azbs check failed");

// Next-cycle implication, disabled while reset is held
`define AZBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("azbs check failed");

`endif

/* rtl/azbs_pkg.sv */
// Shared types, constants and helper functions for the azimuth bin selector.
// No dependencies; imported by every module of the block.
package azbs_pkg;

    // Limits of the configuration
    localparam int MAX_BINS          = 1024;
    localparam int MAX_AZIMUTH       = 255;
    localparam int AZBS_CORDIC_STEPS = 16;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_NUM_BINS     = 2'd0;
    localparam logic [1:0] REG_BETA_STEPS   = 2'd1;
    localparam logic [1:0] REG_CENTER_POS   = 2'd2;
    localparam logic [1:0] REG_WINDOW_WIDTH = 2'd3;

    // Task queue depth
    localparam int Q_DEPTH = 4;

    // Datapath widths: x/y carry 8 guard bits, angle has 2^31 = pi
    localparam int XW = 36;
    localparam int AW = 34;

    // 1/K of the CORDIC in Q0.30
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    localparam logic signed [XW-1:0] OUT_MAX_X = 36'sd16777215;

    // atan(2^-i) with 2^31 = pi
    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [10:0] num_bins;
        logic [7:0]  beta_steps;
        logic [7:0]  center_pos;
        logic [7:0]  window_width;
    } azbs_cfg_t;

    typedef struct packed {
        logic [15:0] right_phase;
        logic [15:0] left_phase;
        logic [23:0] right_mag;
        logic [23:0] left_mag;
    } azbs_item_t;

    // Per-bin bookkeeping that rides along the rotation pipeline
    typedef struct packed {
        logic [9:0] bin_index;
        logic       sel;
        logic       last;
        logic       dc_nyq;
    } azbs_tag_t;

    // One bin handed from the front to the back
    typedef struct packed {
        azbs_tag_t   tag;
        logic [23:0] mag;
        logic [15:0] phase;
    } azbs_task_t;

    typedef struct packed {
        logic [9:0]         bin_index;
        logic signed [24:0] real_part;
        logic signed [24:0] imag_part;
        logic               selected;
        logic               last_bin;
    } azbs_result_t;

    // Round away 8 guard bits to nearest and saturate to +-(2^24-1)
    function automatic logic signed [24:0] azbs_round_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v + 36'sd128) >>> 8;
        if (t > OUT_MAX_X) begin
            t = OUT_MAX_X;
        end else if (t < -OUT_MAX_X) begin
            t = -OUT_MAX_X;
        end
        return t[24:0];
    endfunction

endpackage

/* rtl/azbs_front.sv */
// Front part: accepts azimuth steps, keeps the first hit of each bin and
// applies the window test. Depends on azbs_pkg.
module azbs_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  azbs_pkg::azbs_cfg_t  cfg,
    input  logic               accept,
    input  azbs_pkg::azbs_item_t item,
    output logic               push,
    output azbs_pkg::azbs_task_t task_out
);
    import azbs_pkg::*;

    logic [7:0]  step_reg, step_next;
    logic [9:0]  bin_reg, bin_next;
    logic        found_reg, found_next;
    logic [23:0] mag_reg, mag_next;
    logic [15:0] phase_reg, phase_next;
    logic [8:0]  az_reg, az_next;

    logic [7:0]  beta, d, hw;
    logic [6:0]  h2;
    logic [10:0] nb;
    logic        bin_end, last, can_pick, sel;
    logic signed [9:0] diff;
    logic [9:0]  adiff;

    // Clamp the configuration
    always_comb begin
        beta = (int'(cfg.beta_steps) > MAX_AZIMUTH) ? 8'(MAX_AZIMUTH) : cfg.beta_steps;
        d    = (cfg.center_pos > beta) ? beta : cfg.center_pos;
        hw   = (cfg.window_width > beta) ? beta : cfg.window_width;
        h2   = hw[7:1];
        if (cfg.num_bins < 11'd2) begin
            nb = 11'd2;
        end else if (int'(cfg.num_bins) > MAX_BINS) begin
            nb = 11'(MAX_BINS);
        end else begin
            nb = cfg.num_bins;
        end
    end

    // Pick the first nonzero magnitude, left before right
    always_comb begin
        found_next = found_reg;
        mag_next   = mag_reg;
        phase_next = phase_reg;
        az_next    = az_reg;
        can_pick   = !found_reg && (step_reg <= beta);
        if (can_pick && item.left_mag != 24'd0) begin
            found_next = 1'b1;
            mag_next   = item.left_mag;
            phase_next = item.left_phase;
            az_next    = {1'b0, step_reg};
        end else if (can_pick && item.right_mag != 24'd0) begin
            found_next = 1'b1;
            mag_next   = item.right_mag;
            phase_next = item.right_phase;
            az_next    = {beta, 1'b0} - {1'b0, step_reg};
        end
    end

    // Window test and end of bin
    always_comb begin
        bin_end = step_reg >= beta;
        last    = {1'b0, bin_reg} >= (nb - 11'd1);
        diff    = $signed({2'b00, d}) - $signed({1'b0, az_next});
        adiff   = diff[9] ? 10'(-diff) : 10'(diff);
        sel     = found_next && (adiff <= {3'b000, h2});
        step_next = bin_end ? 8'd0 : step_reg + 8'd1;
        if (bin_end) begin
            bin_next = last ? 10'd0 : bin_reg + 10'd1;
        end else begin
            bin_next = bin_reg;
        end
    end

    always_comb begin
        push                  = accept && bin_end;
        task_out.tag.bin_index = bin_reg;
        task_out.tag.sel       = sel;
        task_out.tag.last      = last;
        task_out.tag.dc_nyq    = (bin_reg == 10'd0) || last;
        task_out.mag           = mag_next;
        task_out.phase         = phase_next;
    end

    // Advance counters and drop the pick at the end of each bin
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            bin_reg   <= '0;
            found_reg <= 1'b0;
        end else if (accept) begin
            step_reg  <= step_next;
            bin_reg   <= bin_next;
            found_reg <= bin_end ? 1'b0 : found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mag_reg   <= mag_next;
            phase_reg <= phase_next;
            az_reg    <= az_next;
        end
    end

endmodule

/* rtl/azbs_queue.sv */
// Short task queue between the front and back parts.
// Depends on azbs_pkg for the task type and depth.
module azbs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  azbs_pkg::azbs_task_t push_task,
    output logic                 has_room,
    input  logic                 pop,
    output logic                 not_empty,
    output azbs_pkg::azbs_task_t head_task
);
    import azbs_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    azbs_task_t    mem_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign has_room  = count_reg < CW'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_task = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Move pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

/* rtl/azbs_back.sv */
// Back part: pipelined CORDIC rotation of each bin's pick and the result
// register. Depends on azbs_pkg.
module azbs_back #(
    parameter int CORDIC_STEPS = azbs_pkg::AZBS_CORDIC_STEPS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   task_valid,
    input  azbs_pkg::azbs_task_t   task_in,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output azbs_pkg::azbs_result_t res
);
    import azbs_pkg::*;

    localparam logic signed [AW-1:0] HALF_PI = 34'sd1073741824;
    localparam logic signed [AW-1:0] PI      = 34'sd2147483648;

    logic adv;

    // Multiply stage
    logic              mul_valid_reg;
    logic [53:0]       prod_reg, prod_next;
    logic signed [AW-1:0] ang0_reg, ang0_next, ang_raw;
    logic              neg_reg, neg_next;
    azbs_tag_t         mtag_reg;

    // Rotation stages; index 0 is the start vector
    logic              valid_reg [CORDIC_STEPS+1];
    azbs_tag_t         tag_reg   [CORDIC_STEPS+1];
    logic signed [XW-1:0] x_reg  [CORDIC_STEPS+1];
    logic signed [XW-1:0] y_reg  [CORDIC_STEPS+1];
    logic signed [AW-1:0] ang_reg[CORDIC_STEPS+1];
    logic signed [XW-1:0] x_next [CORDIC_STEPS];
    logic signed [XW-1:0] y_next [CORDIC_STEPS];
    logic signed [AW-1:0] ang_next[CORDIC_STEPS];
    logic signed [XW-1:0] x_seed;

    // Result register
    logic              out_valid_reg;
    azbs_result_t      res_reg, res_next;

    // Whole pipeline moves while the result register is free or being taken
    assign adv       = !out_valid_reg || res_ready;
    assign pop       = adv && task_valid;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Scale by 1/K and fold the angle into +-pi/2
    always_comb begin
        prod_next = 54'(task_in.mag) * 54'(KINV_Q30);
        ang_raw   = {{(AW-32){task_in.phase[15]}}, task_in.phase, 16'h0000};
        ang0_next = ang_raw;
        neg_next  = 1'b0;
        if (ang_raw > HALF_PI) begin
            ang0_next = ang_raw - PI;
            neg_next  = 1'b1;
        end else if (ang_raw < -HALF_PI) begin
            ang0_next = ang_raw + PI;
            neg_next  = 1'b1;
        end
    end

    assign x_seed = neg_reg ? -$signed({4'b0000, prod_reg[53:22]})
                            :  $signed({4'b0000, prod_reg[53:22]});

    // One micro-rotation per stage
    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (!ang_reg[k][AW-1]) begin
                x_next[k]   = x_reg[k] - (y_reg[k] >>> k);
                y_next[k]   = y_reg[k] + (x_reg[k] >>> k);
                ang_next[k] = ang_reg[k] - $signed({2'b00, ATAN_TAB[k]});
            end else begin
                x_next[k]   = x_reg[k] + (y_reg[k] >>> k);
                y_next[k]   = y_reg[k] - (x_reg[k] >>> k);
                ang_next[k] = ang_reg[k] + $signed({2'b00, ATAN_TAB[k]});
            end
        end
    end

    // Round, saturate, zero what is not selected and zero the imaginary part of DC and Nyquist bins
    always_comb begin
        res_next.bin_index = tag_reg[CORDIC_STEPS].bin_index;
        res_next.selected  = tag_reg[CORDIC_STEPS].sel;
        res_next.last_bin  = tag_reg[CORDIC_STEPS].last;
        res_next.real_part = '0;
        res_next.imag_part = '0;
        if (tag_reg[CORDIC_STEPS].sel) begin
            res_next.real_part = azbs_round_sat(x_reg[CORDIC_STEPS]);
            if (!tag_reg[CORDIC_STEPS].dc_nyq) begin
                res_next.imag_part = azbs_round_sat(y_reg[CORDIC_STEPS]);
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            mul_valid_reg <= task_valid;
            valid_reg[0]  <= mul_valid_reg;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                valid_reg[k+1] <= valid_reg[k];
            end
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg   <= prod_next;
            ang0_reg   <= ang0_next;
            neg_reg    <= neg_next;
            mtag_reg   <= task_in.tag;
            x_reg[0]   <= x_seed;
            y_reg[0]   <= '0;
            ang_reg[0] <= ang0_reg;
            tag_reg[0] <= mtag_reg;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                x_reg[k+1]   <= x_next[k];
                y_reg[k+1]   <= y_next[k];
                ang_reg[k+1] <= ang_next[k];
                tag_reg[k+1] <= tag_reg[k];
            end
            res_reg <= res_next;
        end
    end

endmodule

/* rtl/azimuth_bin_select_resynth.sv */
// Top level of the azimuth bin selector with polar-to-rectangular resynthesis.
// Depends on azbs_pkg, azbs_front, azbs_queue and azbs_back.
//
// Use:
//   The s_ channel takes the azimuth plane one step per beat, beta+1 beats per
//   spectrum bin, bins in order. Each bin gives one beat on the m_ channel:
//   bin index, real and imaginary part in tdata, the selected flag in tuser,
//   and tlast on the final bin of the frame.
//   Registers (num_bins, beta_steps, center_pos, window_width) are written on
//   the APB port while the block is idle; pready is tied high.
// Timing:
//   Input throughput is one beat per cycle while s_tready is high. A bin goes
//   from the task queue through the multiply, start-vector, CORDIC_STEPS
//   rotation and output stages to m_tvalid once its last step is taken. Up to
//   one result per cycle leaves when beta is zero and m_tready stays high.
// Reset:
//   aresetn (synchronous, active low) clears the step and bin counters, the
//   task queue and all pipeline valid bits; registers return to their defaults.
// Stall:
//   When m_tready is low the result is held and the pipeline freezes; input
//   beats are still taken until the four-entry task queue is full, then
//   s_tready falls.
module azimuth_bin_select_resynth #(
    parameter int CORDIC_STEPS = azbs_pkg::AZBS_CORDIC_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: left_mag[23:0], right_mag[47:24], left_phase[63:48], right_phase[79:64]
    input  logic [79:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: bin_index[9:0], real_part[34:10], imag_part[59:35], zero pad[63:60]
    output logic [63:0] m_tdata,
    // tuser: selected[0]
    output logic        m_tuser,
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import azbs_pkg::*;

    azbs_cfg_t    cfg_reg;
    azbs_item_t   item;
    azbs_task_t   front_task, head_task;
    azbs_result_t res;
    logic         accept, push, has_room, pop, not_empty;
    logic         wr_en;
    logic [1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_bins     <= 11'd513;
            cfg_reg.beta_steps   <= 8'd100;
            cfg_reg.center_pos   <= 8'd50;
            cfg_reg.window_width <= 8'd50;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NUM_BINS:     cfg_reg.num_bins     <= pwdata[10:0];
                REG_BETA_STEPS:   cfg_reg.beta_steps   <= pwdata[7:0];
                REG_CENTER_POS:   cfg_reg.center_pos   <= pwdata[7:0];
                REG_WINDOW_WIDTH: cfg_reg.window_width <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_NUM_BINS:     prdata = {21'd0, cfg_reg.num_bins};
            REG_BETA_STEPS:   prdata = {24'd0, cfg_reg.beta_steps};
            REG_CENTER_POS:   prdata = {24'd0, cfg_reg.center_pos};
            REG_WINDOW_WIDTH: prdata = {24'd0, cfg_reg.window_width};
            default:          prdata = '0;
        endcase
    end

    // Unpack the input beat
    always_comb begin
        item.left_mag    = s_tdata[23:0];
        item.right_mag   = s_tdata[47:24];
        item.left_phase  = s_tdata[63:48];
        item.right_phase = s_tdata[79:64];
    end

    assign s_tready = has_room;
    assign accept   = s_tvalid && has_room;

    azbs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .accept   (accept),
        .item     (item),
        .push     (push),
        .task_out (front_task)
    );

    azbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_task (front_task),
        .has_room  (has_room),
        .pop       (pop),
        .not_empty (not_empty),
        .head_task (head_task)
    );

    azbs_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .task_valid (not_empty),
        .task_in    (head_task),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    // Pack the result beat
    assign m_tdata = {4'b0000, res.imag_part, res.real_part, res.bin_index};
    assign m_tuser = res.selected;
    assign m_tlast = res.last_bin;

endmodule

/* rtl/azbs_checker.sv */
// Port-level checker for the azimuth bin selector, bound to the top level.
// Depends on the assertion macros in azimuth_bin_select_resynth_defines.svh.
`include "azimuth_bin_select_resynth_defines.svh"

module azbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result beat
    `AZBS_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // An unselected bin carries zero real and imaginary parts
    `AZBS_ASSERT_NOW(a_unselected_zero, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata[59:10] == 50'd0)

    // DC bin keeps the real part only
    `AZBS_ASSERT_NOW(a_dc_real, aclk, aresetn, m_tvalid && (m_tdata[9:0] == 10'd0),
        m_tdata[59:35] == 25'd0)

    // Nyquist bin keeps the real part only
    `AZBS_ASSERT_NOW(a_nyq_real, aclk, aresetn, m_tvalid && m_tlast,
        m_tdata[59:35] == 25'd0)

endmodule

bind azimuth_bin_select_resynth azbs_checker u_azbs_checker (.*);

/* sim/azbs_bin_checker.sv */
// Scoreboard for the azimuth bin selector: mirrors register writes, predicts each bin result.
// Depends on azbs_pkg; watches the s_, m_ and APB signals of the block without driving them.
`timescale 1ns / 100ps

module azbs_bin_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // tdata: left_mag, right_mag, left_phase, right_phase
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // tdata: bin_index, real_part, imag_part, zero pad
    input  logic [63:0] m_tdata,
    // tuser: selected
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    import azbs_pkg::*;

    localparam longint HALF_PI = 64'sd1073741824;
    localparam longint FULL_PI = 64'sd2147483648;
    localparam longint OUT_LIM = 64'sd16777215;

    // Register mirror
    logic [10:0] nb_reg;
    logic [7:0]  beta_reg;
    logic [7:0]  centre_reg;
    logic [7:0]  window_reg;

    // Scan state of the current bin
    logic [7:0]         step_q;
    logic [9:0]         bin_q;
    logic               found_q;
    logic [23:0]        pick_mag;
    logic signed [15:0] pick_phase;
    logic [8:0]         pick_az;

    azbs_result_t pending_bins[$];
    azbs_result_t got;
    azbs_result_t want;
    azbs_result_t fresh;
    int           fails;
    int           seen;

    // Rotate (mag, phase) onto the real and imaginary axes, 8 guard bits kept
    function automatic void polar_to_rect(input logic [23:0] mag, input logic signed [15:0] ph,
                                          output longint re, output longint im);
        longint          ang;
        longint          x;
        longint          y;
        longint          dx;
        longint          dy;
        longint unsigned prod;
        ang  = longint'(ph) * 65536;
        prod = 64'(mag) * 64'(KINV_Q30);
        x    = longint'(prod >> 22);
        y    = 0;
        // fold the outer half-planes by pi
        if (ang > HALF_PI) begin
            ang = ang - FULL_PI;
            x   = -x;
        end else if (ang < -HALF_PI) begin
            ang = ang + FULL_PI;
            x   = -x;
        end
        for (int i = 0; i < AZBS_CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x   = x - dx;
                y   = y + dy;
                ang = ang - longint'(ATAN_TAB[i]);
            end else begin
                x   = x + dx;
                y   = y - dy;
                ang = ang + longint'(ATAN_TAB[i]);
            end
        end
        re = x;
        im = y;
    endfunction

    // Drop the guard bits with rounding, clamp symmetrically to 24 bits of magnitude
    function automatic logic [24:0] round_clamp25(input longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > OUT_LIM) begin
            r = OUT_LIM;
        end else if (r < -OUT_LIM) begin
            r = -OUT_LIM;
        end
        return r[24:0];
    endfunction

    // Take one azimuth step; returns 1 with the bin result when the bin closes
    function automatic bit scan_azimuth_step(input azbs_item_t it, output azbs_result_t res);
        int unsigned beta;
        int unsigned nb;
        int unsigned t;
        int unsigned d;
        int unsigned h2;
        int          diff;
        bit          last_b;
        bit          sel;
        longint      re;
        longint      im;
        beta = (beta_reg > MAX_AZIMUTH) ? MAX_AZIMUTH : beta_reg;
        nb   = (nb_reg < 2) ? 2 : ((nb_reg > MAX_BINS) ? MAX_BINS : nb_reg);
        t    = step_q;
        re   = 0;
        im   = 0;
        res  = '0;

        // first nonzero magnitude wins, left before right
        if (!found_q && t <= beta) begin
            if (it.left_mag != 0) begin
                found_q    = 1'b1;
                pick_mag   = it.left_mag;
                pick_phase = it.left_phase;
                pick_az    = 9'(t);
            end else if (it.right_mag != 0) begin
                found_q    = 1'b1;
                pick_mag   = it.right_mag;
                pick_phase = it.right_phase;
                pick_az    = 9'(2 * beta - t);
            end
        end

        if (t < beta) begin
            step_q = 8'(t + 1);
            return 1'b0;
        end

        // close the bin: window test around the centre
        d    = (centre_reg > beta) ? beta : centre_reg;
        h2   = ((window_reg > beta) ? beta : window_reg) / 2;
        diff = int'(d) - int'(pick_az);
        if (diff < 0) begin
            diff = -diff;
        end
        sel    = found_q && (diff <= int'(h2));
        last_b = bin_q >= nb - 1;

        if (sel) begin
            polar_to_rect(pick_mag, pick_phase, re, im);
            if (bin_q == 0 || last_b) begin
                im = 0;
            end
            res.real_part = round_clamp25(re);
            res.imag_part = round_clamp25(im);
        end
        res.bin_index = bin_q;
        res.selected  = sel;
        res.last_bin  = last_b;

        bin_q      = last_b ? 10'd0 : bin_q + 10'd1;
        step_q     = '0;
        found_q    = 1'b0;
        pick_mag   = '0;
        pick_phase = '0;
        pick_az    = '0;
        return 1'b1;
    endfunction

    function automatic int field_mismatch(input string name, input longint exp_v,
                                          input longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Track registers, compare result beats, predict from input beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            nb_reg     = 11'd513;
            beta_reg   = 8'd100;
            centre_reg = 8'd50;
            window_reg = 8'd50;
            step_q     = '0;
            bin_q      = '0;
            found_q    = 1'b0;
            pick_mag   = '0;
            pick_phase = '0;
            pick_az    = '0;
            pending_bins.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_NUM_BINS:     nb_reg     = pwdata[10:0];
                    REG_BETA_STEPS:   beta_reg   = pwdata[7:0];
                    REG_CENTER_POS:   centre_reg = pwdata[7:0];
                    REG_WINDOW_WIDTH: window_reg = pwdata[7:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                seen++;
                got.bin_index = m_tdata[9:0];
                got.real_part = m_tdata[34:10];
                got.imag_part = m_tdata[59:35];
                got.selected  = m_tuser;
                got.last_bin  = m_tlast;
                if (pending_bins.size() == 0) begin
                    $error("result beat for bin %0d arrived with nothing expected",
                           got.bin_index);
                    fails++;
                end else begin
                    want  = pending_bins.pop_front();
                    fails += field_mismatch("bin_index", want.bin_index, got.bin_index);
                    fails += field_mismatch("real_part", want.real_part, got.real_part);
                    fails += field_mismatch("imag_part", want.imag_part, got.imag_part);
                    fails += field_mismatch("selected", want.selected, got.selected);
                    fails += field_mismatch("last_bin", want.last_bin, got.last_bin);
                end
            end

            if (s_tvalid && s_tready) begin
                if (scan_azimuth_step(azbs_item_t'(s_tdata), fresh)) begin
                    pending_bins.push_back(fresh);
                end
            end
        end
        fail_count   <= fails;
        pending      <= pending_bins.size();
        results_seen <= seen;
    end

endmodule

/* sim/tb_azimuth_bin_select_resynth.sv */
// Testbench top for azimuth_bin_select_resynth: clock, reset, APB set-up and stream stimulus.
// Depends on azbs_pkg, the block itself and azbs_bin_checker, which does the result checking.
`timescale 1ns / 100ps

module tb_azimuth_bin_select_resynth;
    import azbs_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = AZBS_CORDIC_STEPS + 8;
    localparam int STEP_TARGET    = 1700;
    localparam int CALM_TAIL      = 250;

    typedef enum int {HIT_NONE, HIT_LEFT, HIT_RIGHT} hit_side_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results_seen;

    int steps_sent   = 0;
    int settings_run = 0;
    int cur_beta     = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    bit idle_en      = 1'b0;
    bit hold_req     = 1'b0;
    bit hold_taken   = 1'b0;

    azimuth_bin_select_resynth dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    azbs_bin_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #5 aclk = ~aclk;

    // Sink: random stall bursts, one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: give up when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("azimuth_bin_select_resynth test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic azbs_item_t rand_step();
        azbs_item_t it;
        it.left_mag    = 24'($urandom);
        it.right_mag   = 24'($urandom);
        it.left_phase  = 16'($urandom);
        it.right_phase = 16'($urandom);
        return it;
    endfunction

    // Nonzero magnitude, biased towards the extremes
    function automatic logic [23:0] rand_mag();
        case ($urandom_range(0, 5))
            0:       return 24'hFFFFFF;
            1:       return 24'h000001;
            2:       return 24'($urandom_range(1, 255));
            default: return 24'($urandom_range(1, 24'hFFFFFF));
        endcase
    endfunction

    // Offer one beat from a falling edge and hold it until taken
    task automatic send_step(input azbs_item_t it);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = it;
        do @(posedge aclk); while (!s_tready);
        steps_sent++;
        @(negedge aclk);
    endtask

    // One well-formed bin: silence up to the hit step, random content after it
    task automatic send_bin(input int beta, input int hit_t, input hit_side_t side,
                            input logic [23:0] mag, input logic [15:0] phase);
        azbs_item_t it;
        for (int t = 0; t <= beta; t++) begin
            it = rand_step();
            if (side == HIT_NONE || t < hit_t) begin
                it.left_mag  = '0;
                it.right_mag = '0;
            end else if (t == hit_t) begin
                if (side == HIT_LEFT) begin
                    it.left_mag   = mag;
                    it.left_phase = phase;
                end else begin
                    it.left_mag    = '0;
                    it.right_mag   = mag;
                    it.right_phase = phase;
                end
            end
            send_step(it);
        end
    endtask

    // Unstructured steps, each magnitude silent half the time
    task automatic send_noise(input int n);
        azbs_item_t it;
        repeat (n) begin
            it = rand_step();
            if ($urandom_range(0, 1)) begin
                it.left_mag = '0;
            end
            if ($urandom_range(0, 1)) begin
                it.right_mag = '0;
            end
            send_step(it);
        end
    endtask

    // Let every expected result out, then the rest of the pipeline
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input int nb, input int beta, input int centre, input int window);
        drain();
        write_reg(REG_NUM_BINS, nb);
        write_reg(REG_BETA_STEPS, beta);
        write_reg(REG_CENTER_POS, centre);
        write_reg(REG_WINDOW_WIDTH, window);
        cur_beta = beta;
        settings_run++;
    endtask

    task automatic random_bin();
        hit_side_t side;
        case ($urandom_range(0, 4))
            0:       side = HIT_NONE;
            1, 2:    side = HIT_LEFT;
            default: side = HIT_RIGHT;
        endcase
        send_bin(cur_beta, $urandom_range(0, cur_beta + 1), side, rand_mag(),
                 16'($urandom));
    endtask

    initial begin
        int n_bins;
        int beta;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        idle_en = 1'b1;

        // Directed: DC and Nyquist, both sides, phase extremes, hit on the last step
        set_config(4, 3, 3, 6);
        send_bin(3, 0, HIT_LEFT, 24'hFFFFFF, 16'h0000);
        send_bin(3, 1, HIT_RIGHT, 24'hFFFFFF, 16'h8000);
        send_bin(3, 0, HIT_RIGHT, 24'hFFFFFF, 16'h7FFF);
        send_bin(3, 0, HIT_NONE, 24'h0, 16'h0);
        send_bin(3, 3, HIT_LEFT, 24'h000001, 16'h4000);
        send_bin(3, 2, HIT_LEFT, 24'h800000, 16'hC000);

        // Register extremes: bin count above the limit, widest beta, then all zero
        set_config(2047, 255, 255, 255);
        send_bin(255, 255, HIT_RIGHT, 24'hFFFFFF, 16'h2000);
        set_config(0, 0, 0, 0);
        repeat (8) random_bin();

        // Back-pressure: one bin per beat while the sink holds off
        set_config(7, 0, 0, 0);
        hold_req = 1'b1;
        repeat (80) send_bin(0, 0, HIT_LEFT, rand_mag(), 16'($urandom));

        // Shrink beta and the frame while a bin is half scanned
        set_config(8, 10, 5, 8);
        repeat (3) random_bin();
        send_noise(6);
        drain();
        write_reg(REG_BETA_STEPS, 2);
        write_reg(REG_NUM_BINS, 2);
        cur_beta = 2;
        send_noise(1);
        repeat (4) random_bin();

        // Random settings, mostly well-formed bins with the odd burst of noise
        while (steps_sent < STEP_TARGET) begin
            if (steps_sent > STEP_TARGET - CALM_TAIL) begin
                idle_en = 1'b0;
            end
            case ($urandom_range(0, 4))
                0: begin
                    beta = $urandom_range(0, 3);
                    set_config($urandom_range(2, 9), beta, $urandom_range(0, 4),
                               $urandom_range(0, 8));
                end
                1: begin
                    beta = $urandom_range(4, 15);
                    set_config($urandom_range(0, 1), beta, $urandom_range(0, 20),
                               $urandom_range(0, 40));
                end
                2: begin
                    beta = $urandom_range(16, 40);
                    set_config($urandom_range(1025, 2047), beta, $urandom_range(0, 255),
                               $urandom_range(0, 255));
                end
                3: begin
                    beta = $urandom_range(1, 8);
                    set_config($urandom_range(2, 6), beta, beta, 255);
                end
                default: begin
                    beta = $urandom_range(0, 12);
                    set_config($urandom_range(2, 30), beta, $urandom_range(0, 12), 0);
                end
            endcase
            n_bins = (cur_beta > 15) ? $urandom_range(2, 3) : $urandom_range(3, 12);
            repeat (n_bins) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise($urandom_range(1, cur_beta + 1));
                end else begin
                    random_bin();
                end
            end
        end

        drain();
        $display("Covered %0d azimuth steps and %0d bin results over %0d register settings,",
                 steps_sent, results_seen, settings_run);
        $display("including a mid-bin reconfiguration and a %0d-cycle sink hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("azimuth_bin_select_resynth test passed");
        end else begin
            $display("azimuth_bin_select_resynth test failed");
        end
        $finish;
    end

endmodule

/* azimuth_bin_select_resynth.f */
+incdir+rtl
rtl/azbs_pkg.sv
rtl/azbs_front.sv
rtl/azbs_queue.sv
rtl/azbs_back.sv
rtl/azimuth_bin_select_resynth.sv
rtl/azbs_checker.sv
sim/azbs_bin_checker.sv
sim/tb_azimuth_bin_select_resynth.sv
